>>> src/upd_pkg.sv
package upd_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCntW  = QAw + 1;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDel   = 8'h7f;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CharQmark = 8'h3f;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharNul   = 8'h00;

  typedef enum logic [1:0] {
    SecPath  = 2'd0,
    SecQuery = 2'd1,
    SecFrag  = 2'd2
  } section_e;

  typedef enum logic [1:0] {
    EscNone = 2'd0,
    EscHigh = 2'd1,
    EscLow  = 2'd2
  } escape_e;

  typedef enum logic [1:0] {
    SegEmpty  = 2'd0,
    SegDot    = 2'd1,
    SegDotDot = 2'd2,
    SegOther  = 2'd3
  } segment_e;

  typedef enum logic [1:0] {
    KindPath   = 2'd0,
    KindQuery  = 2'd1,
    KindStatus = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    VerdictOk        = 2'd0,
    VerdictBad       = 2'd1,
    VerdictForbidden = 2'd2
  } verdict_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    verdict_e   verdict;
    logic       end_mark;
  } result_t;

  // n is the number of results of one beat, r0 goes out before r1
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // bit 4 set when the byte is a hex digit, low bits its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> src/upd_core.sv
module upd_core import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output push_t      push_o
);

  section_e   sec_q, sec_d;
  escape_e    esc_q, esc_d;
  segment_e   seg_q, seg_d;
  logic [3:0] hn_q, hn_d;
  logic       first_q, first_d;
  logic       bad_q, bad_d;
  logic       dd_q, dd_d;

  always_comb begin
    logic       fresh;
    logic       do_char;
    logic       end_now;
    logic       emit_byte;
    logic [7:0] c;
    logic [4:0] hx;
    kind_e      bkind;
    verdict_e   v;
    result_t    rb;
    result_t    rs;

    sec_d     = sec_q;
    esc_d     = esc_q;
    seg_d     = seg_q;
    hn_d      = hn_q;
    dd_d      = dd_q;
    first_d   = 1'b0;
    fresh     = 1'b1;
    do_char   = 1'b0;
    end_now   = 1'b0;
    emit_byte = 1'b0;
    bkind     = KindPath;
    c         = byte_i;
    hx        = hex_nibble(byte_i);

    bad_d = bad_q | (byte_i <= CharSpace) | (byte_i == CharDel)
          | (first_q & (byte_i != CharSlash));

    unique case (sec_q)
      SecPath: begin
        if (esc_q != EscNone) begin
          if (!hx[4]) begin
            bad_d = 1'b1;
            esc_d = EscNone;
          end else if (esc_q == EscHigh) begin
            hn_d  = hx[3:0];
            esc_d = EscLow;
            fresh = 1'b0;
          end else begin
            c       = {hn_q, hx[3:0]};
            esc_d   = EscNone;
            do_char = 1'b1;
            fresh   = 1'b0;
          end
        end
        if (fresh) begin
          priority if (byte_i == CharPct) begin
            esc_d = EscHigh;
          end else if (byte_i == CharQmark) begin
            end_now = 1'b1;
            sec_d   = SecQuery;
          end else if (byte_i == CharHash) begin
            end_now = 1'b1;
            sec_d   = SecFrag;
          end else begin
            do_char = 1'b1;
          end
        end
      end
      SecQuery: begin
        if (byte_i == CharHash) begin
          sec_d = SecFrag;
        end else begin
          emit_byte = 1'b1;
          bkind     = KindQuery;
        end
      end
      default: ;
    endcase

    // segments are tracked on decoded bytes
    if (do_char) begin
      emit_byte = 1'b1;
      if (c == CharNul) bad_d = 1'b1;
      if (c == CharSlash) begin
        if (seg_d == SegDotDot) dd_d = 1'b1;
        seg_d = SegEmpty;
      end else if (c == CharDot) begin
        unique case (seg_d)
          SegEmpty:  seg_d = SegDot;
          SegDot:    seg_d = SegDotDot;
          default:   seg_d = SegOther;
        endcase
      end else begin
        seg_d = SegOther;
      end
    end

    if (last_i && sec_d == SecPath) end_now = 1'b1;
    if (end_now) begin
      if (esc_d != EscNone) bad_d = 1'b1;
      esc_d = EscNone;
      if (seg_d == SegDotDot) dd_d = 1'b1;
      seg_d = SegEmpty;
    end

    v  = bad_d ? VerdictBad : (dd_d ? VerdictForbidden : VerdictOk);
    rb = '{kind: bkind, data: c, verdict: VerdictOk, end_mark: 1'b0};
    rs = '{kind: KindStatus, data: 8'd0, verdict: v, end_mark: 1'b1};

    push_o.r1 = rs;
    if (emit_byte) begin
      push_o.r0 = rb;
      push_o.n  = last_i ? 2'd2 : 2'd1;
    end else begin
      push_o.r0 = rs;
      push_o.n  = last_i ? 2'd1 : 2'd0;
    end
    if (!advance_i) push_o.n = 2'd0;

    if (last_i) begin
      sec_d   = SecPath;
      esc_d   = EscNone;
      seg_d   = SegEmpty;
      hn_d    = 4'd0;
      first_d = 1'b1;
      bad_d   = 1'b0;
      dd_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= SecPath;
      esc_q   <= EscNone;
      seg_q   <= SegEmpty;
      hn_q    <= 4'd0;
      first_q <= 1'b1;
      bad_q   <= 1'b0;
      dd_q    <= 1'b0;
    end else if (advance_i) begin
      sec_q   <= sec_d;
      esc_q   <= esc_d;
      seg_q   <= seg_d;
      hn_q    <= hn_d;
      first_q <= first_d;
      bad_q   <= bad_d;
      dd_q    <= dd_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_i |=> first_q && sec_q == SecPath && !bad_q && !dd_q)
    else $error("state not cleared after final beat");

  a_two_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n == 2'd2 |-> push_o.r1.kind == KindStatus && push_o.r0.kind != KindStatus)
    else $error("byte result must precede status");

  a_no_escape_off_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q != SecPath |-> esc_q == EscNone)
    else $error("escape pending outside path");

  a_first_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> sec_q == SecPath && seg_q == SegEmpty)
    else $error("first byte state inconsistent");

endmodule

>>> src/upd_outq.sv
module upd_outq import upd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    valid_o,
  output logic    space_o
);

  result_t          mem_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] after_pop;
  logic             pop;

  assign valid_o   = cnt_q != '0;
  assign head_o    = mem_q[rd_q];
  assign pop       = pop_i & valid_o;
  assign after_pop = cnt_q - QCntW'(pop);
  // room for the worst case of two results per beat
  assign space_o   = after_pop <= QCntW'(QDepth - 2);
  assign cnt_d     = after_pop + QCntW'(push_i.n);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + QAw'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QAw'(push_i.n);
      rd_q  <= rd_q + QAw'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> cnt_d <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != QCntW'(QDepth) && cnt_q != '0 |-> wr_q != rd_q)
    else $error("queue pointers disagree with count");

endmodule

>>> src/uri_path_decoder_unit.sv
// streaming request uri checker and path percent-decoder
// input channel: in_valid_i/in_ready_o with uri_byte_i and is_last_i, one
//   raw uri byte per beat, is_last_i marks the final byte of the uri
// output channel: out_valid_o/out_ready_i with kind_o, out_byte_o,
//   verdict_o and end_mark_o; a beat is a decoded path byte, a raw query
//   byte, or the final status that closes the uri (end_mark_o high)
// an input beat yields zero, one or two output beats; when two, the byte
//   comes before the status
// pipeline: two register stages, the input stage and then the result queue;
//   an accepted byte waits in the input stage until the queue has room,
//   and its results are then written into the result queue
// throughput: one input beat per cycle, limited by the output side taking
//   one result per cycle; the four-entry result queue only admits a new
//   beat while two entries are free
// reset clears the input stage, the decoder state and the result queue;
//   the next byte is taken as the first byte of a new uri
// when the receiver stalls, results wait in the queue and the input stage
//   holds its byte, so in_ready_o drops once the queue is nearly full
module uri_path_decoder_unit import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] uri_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] verdict_o,
  output logic       end_mark_o
);

  logic       stg_v_q, stg_v_d;
  logic [7:0] stg_byte_q;
  logic       stg_last_q;
  logic       advance;
  logic       space;
  logic       in_fire;
  push_t      push;
  result_t    head;

  assign advance    = stg_v_q & space;
  assign in_ready_o = ~stg_v_q | advance;
  assign in_fire    = in_valid_i & in_ready_o;
  assign stg_v_d    = in_fire | (stg_v_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_byte_q <= uri_byte_i;
      stg_last_q <= is_last_i;
    end
  end

  upd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (stg_byte_q),
    .last_i    (stg_last_q),
    .push_o    (push)
  );

  upd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .space_o (space)
  );

  assign kind_o     = head.kind;
  assign out_byte_o = head.data;
  assign verdict_o  = head.verdict;
  assign end_mark_o = head.end_mark;

endmodule
